// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file utf8d_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form: when cond holds, prop must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// ----- rtl/core/utf8d_pkg.sv -----
package utf8d_pkg;

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] ASCII_END  = 8'h80;
   localparam logic [7:0] LEAD2_MIN  = 8'hC2;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD5_MIN  = 8'hF8;
   localparam logic [7:0] LEAD6_MIN  = 8'hFC;
   localparam logic [7:0] LEAD_END   = 8'hFE;
   localparam logic [7:0] OVL3_MIN   = 8'hA0;
   localparam logic [7:0] OVL4_MIN   = 8'h90;
   localparam logic [7:0] OVL5_MIN   = 8'h88;
   localparam logic [7:0] OVL6_MIN   = 8'h84;
   localparam logic [1:0] CONT_TAG   = 2'b10;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ILSEQ = 2'd1,
      ST_CTRL  = 2'd2,
      ST_TRUNC = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  remaining;
      logic [30:0] acc;
      logic [7:0]  lead;
      logic [2:0]  total;
   } dec_state_type;

   typedef struct packed {
      logic        valid;
      logic [30:0] code_point;
      status_type  status;
      logic [2:0]  seq_length;
   } dec_result_type;

endpackage

// ----- rtl/core/utf8d_step.sv -----
module utf8d_step
   import utf8d_pkg::*;
(
   input  logic [7:0]     in_byte,
   input  logic           end_of_text,
   input  dec_state_type  cur,
   output dec_state_type  nxt,
   output dec_result_type res
);

   logic [2:0]  total;
   logic [7:0]  lead_mask;
   logic        first_cont;
   logic        overlong;
   logic [30:0] acc_next;
   logic [2:0]  rem_next;

   always_comb begin
      total     = 3'd2;
      lead_mask = 8'h1F;
      if (in_byte inside {[LEAD6_MIN:8'hFD]}) begin
         total     = 3'd6;
         lead_mask = 8'h01;
      end else if (in_byte inside {[LEAD5_MIN:8'hFB]}) begin
         total     = 3'd5;
         lead_mask = 8'h03;
      end else if (in_byte inside {[LEAD4_MIN:8'hF7]}) begin
         total     = 3'd4;
         lead_mask = 8'h07;
      end else if (in_byte inside {[LEAD3_MIN:8'hEF]}) begin
         total     = 3'd3;
         lead_mask = 8'h0F;
      end
   end

   assign first_cont = ((cur.remaining + 3'd1) == cur.total);
   assign overlong   = (cur.lead == LEAD3_MIN && in_byte < OVL3_MIN) ||
                       (cur.lead == LEAD4_MIN && in_byte < OVL4_MIN) ||
                       (cur.lead == LEAD5_MIN && in_byte < OVL5_MIN) ||
                       (cur.lead == LEAD6_MIN && in_byte < OVL6_MIN);
   assign acc_next   = {cur.acc[24:0], in_byte[5:0]};
   assign rem_next   = cur.remaining - 3'd1;

   always_comb begin
      nxt = cur;
      res = '0;
      if (cur.remaining == 3'd0) begin
         if (in_byte < CTRL_LIMIT) begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = ST_CTRL;
         end else if (in_byte < ASCII_END) begin
            res.valid      = 1'b1;
            res.code_point = {23'd0, in_byte};
            res.status     = ST_OK;
            res.seq_length = 3'd1;
         end else if (in_byte < LEAD2_MIN || in_byte >= LEAD_END) begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = ST_ILSEQ;
         end else if (end_of_text) begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = ST_TRUNC;
         end else begin
            nxt.remaining = total - 3'd1;
            nxt.acc       = {23'd0, in_byte & lead_mask};
            nxt.lead      = in_byte;
            nxt.total     = total;
         end
      end else begin
         if (in_byte[7:6] != CONT_TAG || (first_cont && overlong)) begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = ST_ILSEQ;
         end else if (rem_next == 3'd0) begin
            nxt            = '0;
            res.valid      = 1'b1;
            res.code_point = acc_next;
            res.status     = ST_OK;
            res.seq_length = cur.total;
         end else if (end_of_text) begin
            nxt        = '0;
            res.valid  = 1'b1;
            res.status = ST_TRUNC;
         end else begin
            nxt.remaining = rem_next;
            nxt.acc       = acc_next;
         end
      end
   end

endmodule

// ----- rtl/core/utf8_stream_decoder.sv -----
// UTF-8 stream decoder (original six-byte form, 31-bit code points). One byte
// beat is taken per cycle when req_ready is high; a result beat appears in the
// cycle after the byte that completes a sequence or makes it fail, and none
// for bytes in the middle of a sequence. The sustained rate is one byte per
// cycle unless a result waits; each byte steps the sequence state. While a result
// beat waits with rsp_ready low, req_ready is low and no byte is taken; with
// rsp_ready high the waiting result leaves in the same cycle a new byte enters.
// Errors (status 1 illegal, 2 control byte, 3 truncated) carry zero code
// point and length and return the decoder to idle, dropping the bad byte.
module utf8_stream_decoder
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_code_point,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_seq_length
);

   dec_state_type  state_ff, state_in;
   dec_result_type step_res;
   logic           rsp_valid_ff;
   logic [30:0]    code_point_ff;
   status_type     status_ff;
   logic [2:0]     seq_length_ff;
   logic           accept;

   utf8d_step u_step (
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .cur         (state_ff),
      .nxt         (state_in),
      .res         (step_res)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && step_res.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_res.valid) begin
         code_point_ff <= step_res.code_point;
         status_ff     <= step_res.status;
         seq_length_ff <= step_res.seq_length;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = code_point_ff;
   assign rsp_status     = status_ff;
   assign rsp_seq_length = seq_length_ff;

endmodule

// ----- rtl/core/utf8d_checker.sv -----
`include "assert_macros.svh"

module utf8d_checker
   import utf8d_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_code_point,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_seq_length
);

   // a result beat only shows up after a byte was taken
   `ASSERT_CLK(a_rsp_needs_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready), "result without a byte beat")

   // stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_code_point) && $stable(rsp_status) && $stable(rsp_seq_length)), "stalled result changed")

   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_code_point == 31'd0 && rsp_seq_length == 3'd0, "error result with data")

   `ASSERT_IMPLIES(a_ok_len, clock, reset, rsp_valid && rsp_status == ST_OK, rsp_seq_length != 3'd0 && rsp_seq_length != 3'd7, "bad sequence length")

   `ASSERT_IMPLIES(a_ascii_range, clock, reset, rsp_valid && rsp_status == ST_OK && rsp_seq_length == 3'd1, rsp_code_point >= 31'h20 && rsp_code_point < 31'h80, "single byte out of range")

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_code_point (rsp_code_point),
   .rsp_status     (rsp_status),
   .rsp_seq_length (rsp_seq_length)
);
